### rtl/aligned_value_slot_allocator_core_defines.svh
// assertion macros for the slot allocator rtl
// no dependencies; pulled in by files that carry concurrent checks
`ifndef ALIGNED_VALUE_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define ALIGNED_VALUE_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define AVSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("avsa check failed");

// next-cycle implication, disabled while reset is asserted (active low)
`define AVSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("avsa check failed");

`endif

### rtl/avsa_pkg.sv
// shared types, codes and helpers of the aligned value slot allocator
// no dependencies
`default_nettype none

package avsa_pkg;

    localparam int DEF_MAX_VALUES    = 64;
    localparam int DEF_FRAME_LIMIT   = 4096;
    localparam int DEF_POINTER_BYTES = 8;

    // fixed port widths
    localparam int OFFSET_W = 12;
    localparam int FLAGS_W  = 4;

    // slot sizes in bytes
    localparam int FOUR_BYTES  = 4;
    localparam int EIGHT_BYTES = 8;
    localparam int V128_BYTES  = 16;
    localparam int V128_MASK   = V128_BYTES - 1;

    // size flag bit positions
    localparam int FLAG_EIGHT   = 0;
    localparam int FLAG_FLOAT   = 1;
    localparam int FLAG_SIXTEEN = 2;
    localparam int FLAG_REF     = 3;

    typedef enum logic [2:0] {
        VT_I32       = 3'd0,
        VT_I64       = 3'd1,
        VT_F32       = 3'd2,
        VT_F64       = 3'd3,
        VT_V128      = 3'd4,
        VT_FUNCREF   = 3'd5,
        VT_EXTERNREF = 3'd6,
        VT_REFERENCE = 3'd7
    } t_vtype;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EMPTY      = 2'd1,
        STAT_STACK_FULL = 2'd2,
        STAT_FRAME_FULL = 2'd3
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    // push decision handed from the allocator to the top level
    typedef struct packed {
        logic    commit;
        t_status status;
    } t_push_ctl;

    function automatic logic [FLAGS_W-1:0] flags_of_type(input t_vtype vt, input logic ptr8);
        logic [FLAGS_W-1:0] f;
        f = '0;
        unique case (vt)
            VT_I32:  f = '0;
            VT_I64:  f[FLAG_EIGHT] = 1'b1;
            VT_F32:  f[FLAG_FLOAT] = 1'b1;
            VT_F64: begin
                f[FLAG_EIGHT] = 1'b1;
                f[FLAG_FLOAT] = 1'b1;
            end
            VT_V128: f[FLAG_SIXTEEN] = 1'b1;
            VT_FUNCREF, VT_EXTERNREF, VT_REFERENCE: begin
                f[FLAG_REF]   = 1'b1;
                f[FLAG_EIGHT] = ptr8;
            end
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/avsa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module avsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/avsa_alloc.sv
// push path: picks an aligned frame slot, reuses holes, pads for v128
// depends on avsa_pkg
`default_nettype none

module avsa_alloc #(
    parameter int FRAME_LIMIT   = 4096,
    parameter int POINTER_BYTES = 8,
    localparam int FW = $clog2(FRAME_LIMIT),
    localparam int SW = FW + 1
) (
    input  wire logic [7:0]               i_register_number,
    input  wire logic [2:0]               i_value_type,
    input  wire logic                     i_stack_full,
    input  wire logic [FW-1:0]            i_size,
    input  wire logic [FW-1:0]            i_four,
    input  wire logic [FW-1:0]            i_eight,
    output logic      [FW-1:0]            o_size,
    output logic      [FW-1:0]            o_four,
    output logic      [FW-1:0]            o_eight,
    output logic      [FW-1:0]            o_offset,
    output logic      [avsa_pkg::FLAGS_W-1:0] o_flags,
    output avsa_pkg::t_push_ctl           o_ctl
);

    import avsa_pkg::*;

    logic [FLAGS_W-1:0] flags;
    logic [SW-1:0]      sz;
    logic [SW-1:0]      four;
    logic [SW-1:0]      eight;
    logic [SW-1:0]      off;
    logic               in_frame;

    always_comb begin
        flags    = flags_of_type(t_vtype'(i_value_type), POINTER_BYTES == EIGHT_BYTES);
        in_frame = (i_register_number == 8'd0);
        sz       = SW'(i_size);
        four     = SW'(i_four);
        eight    = SW'(i_eight);
        off      = '0;

        if (in_frame) begin
            if (flags[FLAG_SIXTEEN]) begin
                if ((sz & SW'(V128_MASK)) != '0) begin
                    if (sz[2]) begin
                        sz   = sz + SW'(FOUR_BYTES);
                        four = sz;
                    end
                    if (sz[3]) begin
                        sz    = sz + SW'(EIGHT_BYTES);
                        eight = sz;
                    end
                end
                off = sz;
                sz  = sz + SW'(V128_BYTES);
            end else if (flags[FLAG_EIGHT]) begin
                if (eight != '0) begin
                    off   = eight - SW'(EIGHT_BYTES);
                    eight = '0;
                end else begin
                    if (sz[2]) begin
                        sz   = sz + SW'(FOUR_BYTES);
                        four = sz;
                    end
                    off = sz;
                    sz  = sz + SW'(EIGHT_BYTES);
                end
            end else if (four != '0) begin
                off  = four - SW'(FOUR_BYTES);
                four = '0;
            end else if (eight != '0) begin
                // split the eight-byte hole, the upper half stays free
                off   = eight - SW'(EIGHT_BYTES);
                four  = eight;
                eight = '0;
            end else begin
                off = sz;
                sz  = sz + SW'(FOUR_BYTES);
            end
        end

        o_size   = i_size;
        o_four   = i_four;
        o_eight  = i_eight;
        o_offset = '0;
        o_flags  = '0;
        priority if (i_stack_full) begin
            o_ctl = '{commit: 1'b0, status: STAT_STACK_FULL};
        end else if (in_frame && (sz >= SW'(FRAME_LIMIT))) begin
            o_ctl = '{commit: 1'b0, status: STAT_FRAME_FULL};
        end else begin
            o_ctl    = '{commit: 1'b1, status: STAT_OK};
            o_size   = sz[FW-1:0];
            o_four   = four[FW-1:0];
            o_eight  = eight[FW-1:0];
            o_offset = off[FW-1:0];
            o_flags  = flags;
        end
    end

endmodule

`default_nettype wire

### rtl/avsa_release.sv
// pop path: returns the top slot to the frame, trims the frame end or records a hole
// depends on avsa_pkg
`default_nettype none

module avsa_release #(
    parameter int FRAME_LIMIT = 4096,
    localparam int FW = $clog2(FRAME_LIMIT),
    localparam int SW = FW + 1
) (
    input  wire logic [FW-1:0]                i_entry_offset,
    input  wire logic                         i_entry_in_register,
    input  wire logic [avsa_pkg::FLAGS_W-1:0] i_entry_flags,
    input  wire logic [FW-1:0]                i_size,
    input  wire logic [FW-1:0]                i_four,
    input  wire logic [FW-1:0]                i_eight,
    output logic      [FW-1:0]                o_size,
    output logic      [FW-1:0]                o_four,
    output logic      [FW-1:0]                o_eight,
    output logic      [FW-1:0]                o_offset
);

    import avsa_pkg::*;

    logic [FW-1:0] ns;
    logic [FW-1:0] nf;
    logic [FW-1:0] ne;
    logic [SW-1:0] off_p4;
    logic [SW-1:0] off_p8;

    always_comb begin
        ns     = i_size;
        nf     = i_four;
        ne     = i_eight;
        off_p4 = SW'(i_entry_offset) + SW'(FOUR_BYTES);
        off_p8 = SW'(i_entry_offset) + SW'(EIGHT_BYTES);

        if (!i_entry_in_register) begin
            if (i_entry_flags[FLAG_SIXTEEN]) begin
                ns = i_entry_offset;
                if ((ns != '0) && (ns == ne)) begin
                    ns = ns - FW'(EIGHT_BYTES);
                    ne = '0;
                end
                if ((ns != '0) && (ns == nf)) begin
                    ns = ns - FW'(FOUR_BYTES);
                    nf = '0;
                end
            end else if (i_entry_flags[FLAG_EIGHT]) begin
                if (SW'(i_size) == off_p8) begin
                    ns = i_entry_offset;
                    if ((ns != '0) && (ns == nf)) begin
                        ns = ns - FW'(FOUR_BYTES);
                        nf = '0;
                    end
                end else begin
                    ne = off_p8[FW-1:0];
                end
            end else begin
                if (SW'(i_size) == off_p4) begin
                    ns = i_size - FW'(FOUR_BYTES);
                end else if (off_p8 == SW'(i_four)) begin
                    // freed slot joins the four-byte hole above it
                    ne = i_four;
                    nf = '0;
                end else begin
                    nf = off_p4[FW-1:0];
                end
            end
        end

        o_size   = ns;
        o_four   = nf;
        o_eight  = ne;
        o_offset = i_entry_in_register ? '0 : i_entry_offset;
    end

endmodule

`default_nettype wire

### rtl/aligned_value_slot_allocator_core.sv
// Aligned value slot allocator. Every input transfer is a push of one value (register
// number and value type) or a pop of the newest value, and yields exactly one result
// transfer with the slot offset, the size flags, the frame size after the operation and
// a status (ok, pop on empty stack, stack full, frame full). The value stack lives in one
// synchronous ram with registered read data; frame size and the two spare holes (one
// four-byte, one eight-byte) sit in registers. A push chooses the slot and writes the entry
// at the accepting edge. A pop of a nonempty stack reads the top entry from the ram and
// finishes in the S_POP state once the result register is free; a pop on an empty stack
// finishes at the accepting edge. Items are worked on one at a time, and while a finished
// result waits under a result stall the input is stalled as well. No clearing pass runs after reset.
// depends on avsa_pkg, avsa_ram, avsa_alloc, avsa_release and the defines header
`default_nettype none

`include "aligned_value_slot_allocator_core_defines.svh"

module aligned_value_slot_allocator_core #(
    parameter int MAX_VALUES    = avsa_pkg::DEF_MAX_VALUES,
    parameter int FRAME_LIMIT   = avsa_pkg::DEF_FRAME_LIMIT,
    parameter int POINTER_BYTES = avsa_pkg::DEF_POINTER_BYTES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_operation,
    input  wire logic [7:0]                      i_register_number,
    input  wire logic [2:0]                      i_value_type,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [avsa_pkg::OFFSET_W-1:0]   o_slot_offset,
    output logic      [avsa_pkg::FLAGS_W-1:0]    o_size_flags,
    output logic      [avsa_pkg::OFFSET_W-1:0]   o_frame_bytes,
    output logic      [1:0]                      o_status
);

    import avsa_pkg::*;

    localparam int FW = $clog2(FRAME_LIMIT);          // frame offsets and sizes
    localparam int AW = $clog2(MAX_VALUES);           // ram address
    localparam int CW = $clog2(MAX_VALUES + 1);       // stack count, holds the depth
    localparam int EW = FW + 1 + FLAGS_W;             // ram word: in_reg, flags, offset

    // control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [FW-1:0] r_size, n_size;
    logic [FW-1:0] r_four, n_four;
    logic [FW-1:0] r_eight, n_eight;
    logic          r_out_valid, n_out_valid;

    // result register
    logic [OFFSET_W-1:0] r_out_offset, n_out_offset;
    logic [FLAGS_W-1:0]  r_out_flags, n_out_flags;
    logic [OFFSET_W-1:0] r_out_frame, n_out_frame;
    t_status             r_out_status, n_out_status;

    logic          out_free;      // result register can take a new result this cycle
    logic          in_xfer;
    logic          stack_full;
    logic [CW-1:0] top_idx;

    // ram ports
    logic          ram_we;
    logic          ram_re;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    // push path
    logic [FW-1:0]      al_size, al_four, al_eight, al_offset;
    logic [FLAGS_W-1:0] al_flags;
    t_push_ctl          al_ctl;

    // pop path
    logic [FW-1:0]      rl_size, rl_four, rl_eight, rl_offset;
    logic [FW-1:0]      ent_offset;
    logic               ent_in_reg;
    logic [FLAGS_W-1:0] ent_flags;

    assign out_free   = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && out_free);
    assign in_xfer    = i_valid && !o_stall;
    assign stack_full = (r_count >= CW'(MAX_VALUES));
    assign top_idx    = r_count - CW'(1);

    assign {ent_in_reg, ent_flags, ent_offset} = ram_rdata;

    // write the new entry on a committed push, read the top entry on a nonempty pop
    assign ram_we    = in_xfer && (t_op'(i_operation) == OP_PUSH) && al_ctl.commit;
    assign ram_re    = in_xfer && (t_op'(i_operation) == OP_POP) && (r_count != '0);
    assign ram_wdata = {(i_register_number != 8'd0), al_flags, al_offset};

    avsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_VALUES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (top_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    avsa_alloc #(
        .FRAME_LIMIT   (FRAME_LIMIT),
        .POINTER_BYTES (POINTER_BYTES)
    ) u_alloc (
        .i_register_number (i_register_number),
        .i_value_type      (i_value_type),
        .i_stack_full      (stack_full),
        .i_size            (r_size),
        .i_four            (r_four),
        .i_eight           (r_eight),
        .o_size            (al_size),
        .o_four            (al_four),
        .o_eight           (al_eight),
        .o_offset          (al_offset),
        .o_flags           (al_flags),
        .o_ctl             (al_ctl)
    );

    avsa_release #(
        .FRAME_LIMIT (FRAME_LIMIT)
    ) u_release (
        .i_entry_offset      (ent_offset),
        .i_entry_in_register (ent_in_reg),
        .i_entry_flags       (ent_flags),
        .i_size              (r_size),
        .i_four              (r_four),
        .i_eight             (r_eight),
        .o_size              (rl_size),
        .o_four              (rl_four),
        .o_eight             (rl_eight),
        .o_offset            (rl_offset)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_size       = r_size;
        n_four       = r_four;
        n_eight      = r_eight;
        n_out_valid  = r_out_valid && i_stall;   // drop the result once it transfers
        n_out_offset = r_out_offset;
        n_out_flags  = r_out_flags;
        n_out_frame  = r_out_frame;
        n_out_status = r_out_status;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (t_op'(i_operation) == OP_PUSH) begin
                        // push finishes in this cycle
                        n_size       = al_size;
                        n_four       = al_four;
                        n_eight      = al_eight;
                        n_count      = al_ctl.commit ? r_count + CW'(1) : r_count;
                        n_out_valid  = 1'b1;
                        n_out_offset = OFFSET_W'(al_offset);
                        n_out_flags  = al_flags;
                        n_out_frame  = OFFSET_W'(al_size);
                        n_out_status = al_ctl.status;
                    end else if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_offset = '0;
                        n_out_flags  = '0;
                        n_out_frame  = OFFSET_W'(r_size);
                        n_out_status = STAT_EMPTY;
                    end else begin
                        // wait for the top entry from the ram
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                // read data holds, so a stalled result side just delays the pop
                if (out_free) begin
                    n_state      = S_IDLE;
                    n_size       = rl_size;
                    n_four       = rl_four;
                    n_eight      = rl_eight;
                    n_count      = top_idx;
                    n_out_valid  = 1'b1;
                    n_out_offset = OFFSET_W'(rl_offset);
                    n_out_flags  = ent_flags;
                    n_out_frame  = OFFSET_W'(rl_size);
                    n_out_status = STAT_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_size      <= '0;
            r_four      <= '0;
            r_eight     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_size      <= n_size;
            r_four      <= n_four;
            r_eight     <= n_eight;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_offset <= n_out_offset;
        r_out_flags  <= n_out_flags;
        r_out_frame  <= n_out_frame;
        r_out_status <= n_out_status;
    end

    assign o_valid       = r_out_valid;
    assign o_slot_offset = r_out_offset;
    assign o_size_flags  = r_out_flags;
    assign o_frame_bytes = r_out_frame;
    assign o_status      = r_out_status;

    // a pop only waits on the ram when there is an entry to read
    `AVSA_ASSERT_NOW(a_pop_has_entry, i_clk, i_rst_n, r_state == S_POP, r_count != '0)
    // the stack never holds more than its depth
    `AVSA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_VALUES))
    // a committed frame never reaches the limit
    `AVSA_ASSERT_NOW(a_frame_bound, i_clk, i_rst_n, 1'b1, int'(r_size) < FRAME_LIMIT)
    // an input transfer never overwrites a result that is still held
    `AVSA_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, in_xfer, !(r_out_valid && i_stall))
    // a nonempty pop always moves on to the ram read stage
    `AVSA_ASSERT_NEXT(a_pop_reads, i_clk, i_rst_n,
        in_xfer && (t_op'(i_operation) == OP_POP) && (r_count != '0), r_state == S_POP)

endmodule

`default_nettype wire
